### hdl/gf2_mq_gray_search_step_defines.svh
// Assertion macros shared by the Gray-code MQ search step RTL.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef GF2_MQ_GRAY_SEARCH_STEP_DEFINES_SVH
`define GF2_MQ_GRAY_SEARCH_STEP_DEFINES_SVH

// Check an implication on every clock edge outside reset.
`define GMQ_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check an invariant on every clock edge outside reset.
`define GMQ_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

`endif

### hdl/gmq_pkg.sv
`timescale 1ns / 1ps
// Types, sizes and command codes of the Gray-code MQ search step.
// No dependencies.
package gmq_pkg;
    localparam int EQUATIONS   = 19;
    localparam int VARIABLES   = 55;
    localparam int SEARCH_BITS = 46;
    localparam int SOLVED_VARS = 9;
    localparam int WORD_W      = 56;
    localparam int ROW_W       = SOLVED_VARS + 1;
    localparam int COL_SEL_W   = $clog2(ROW_W);
    localparam int ADDR_W      = $clog2(VARIABLES);
    localparam int TOP_W       = WORD_W - SEARCH_BITS;
    localparam logic [TOP_W-1:0] GP_TOP = '1;

    typedef enum logic [1:0] {
        CMD_DERIV = 2'd0,
        CMD_EQW   = 2'd1,
        CMD_START = 2'd2,
        CMD_STEP  = 2'd3
    } t_cmd;

    typedef struct packed {
        logic                   load;
        logic                   elim;
        logic                   upd;
        logic                   rd_en;
        logic [COL_SEL_W-1:0]   col_sel;
        logic [ROW_W-1:0]       pivot_row;
        logic [ADDR_W-1:0]      wr_addr;
        logic [ADDR_W-1:0]      rd_addr;
        logic [WORD_W-1:0]      wr_data;
        logic [WORD_W-1:0]      mask;
    } t_cell_ctrl;

    typedef struct packed {
        logic                   pivot;
        logic                   free;
        logic [ROW_W-1:0]       row;
        logic [SOLVED_VARS-1:0] sol;
    } t_cell_stat;
endpackage

### hdl/gmq_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for command items and result items.
// Depends on gmq_pkg.
interface gmq_in_if import gmq_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [1:0]             command;
    logic [4:0]             row;
    logic [5:0]             column;
    logic [WORD_W-1:0]      data;
    logic [SEARCH_BITS-1:0] key;
    modport source (output valid, command, row, column, data, key, input ready);
    modport sink (input valid, command, row, column, data, key, output ready);
endinterface

interface gmq_out_if import gmq_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic                   solved;
    logic [SEARCH_BITS-1:0] key_out;
    logic [SEARCH_BITS-1:0] guess_bits;
    logic [SOLVED_VARS-1:0] solution;
    modport source (output valid, solved, key_out, guess_bits, solution, input ready);
    modport sink (input valid, solved, key_out, guess_bits, solution, output ready);
endinterface

### hdl/gmq_cell.sv
`timescale 1ns / 1ps
// One equation cell: equation word, derivative bank and one row of the
// linear system, with pivot and solution priority chains. Depends on gmq_pkg.
module gmq_cell import gmq_pkg::*; (
    input  logic                   i_clk,
    input  t_cell_ctrl             i_ctrl,
    input  logic                   i_deriv_we,
    input  logic                   i_eq_we,
    input  logic                   i_found,
    output logic                   o_found,
    input  logic [SOLVED_VARS-1:0] i_seen,
    output logic [SOLVED_VARS-1:0] o_seen,
    output t_cell_stat             o_stat
);
    logic [WORD_W-1:0] r_deriv [VARIABLES];
    logic [WORD_W-1:0] r_rd;
    logic [WORD_W-1:0] r_eq;
    logic [ROW_W-1:0]  r_row;
    logic              r_free;
    logic [ROW_W-1:0]  w_build;
    logic              w_cand;

    always_comb begin
        for (int k = 0; k < SOLVED_VARS; k++) begin
            w_build[k] = r_eq[VARIABLES-1-k];
        end
        w_build[SOLVED_VARS] = (^r_eq[SEARCH_BITS-1:0]) ^ r_eq[WORD_W-1];
    end

    // Highest free row with the current column set wins the pivot.
    assign w_cand  = r_row[i_ctrl.col_sel] & r_free;
    assign o_found = i_found | w_cand;
    assign o_seen  = i_seen | r_row[SOLVED_VARS-1:0];

    always_comb begin
        o_stat.pivot = i_ctrl.elim & w_cand & ~i_found;
        o_stat.free  = r_free;
        o_stat.row   = r_row;
        for (int k = 0; k < SOLVED_VARS; k++) begin
            o_stat.sol[SOLVED_VARS-1-k] = r_row[k] & ~i_seen[k] & r_row[SOLVED_VARS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_deriv_we) begin
            r_deriv[i_ctrl.wr_addr] <= i_ctrl.wr_data;
        end
        if (i_ctrl.rd_en) begin
            r_rd <= r_deriv[i_ctrl.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_eq_we) begin
            r_eq <= i_ctrl.wr_data;
        end else if (i_ctrl.upd) begin
            r_eq <= r_eq ^ (r_rd & i_ctrl.mask);
        end
        if (i_ctrl.load) begin
            r_row  <= w_build;
            r_free <= 1'b1;
        end else if (i_ctrl.elim) begin
            if (o_stat.pivot) begin
                r_free <= 1'b0;
            end else if (r_row[i_ctrl.col_sel]) begin
                r_row <= r_row ^ i_ctrl.pivot_row;
            end
        end
    end
endmodule

### hdl/gf2_mq_gray_search_step.sv
`timescale 1ns / 1ps
// Top level of the Gray-code MQ search step: control, Gray point and a
// chain of equation cells. Depends on gmq_pkg, gmq_if, gmq_cell, defines.
//
//  port    | dir | carries
//  --------+-----+----------------------------------------------
//  i_in    | in  | command item: command, row, column, data, key
//  o_out   | out | result item: solved, key_out, guess_bits, solution
//
// Write and start-key items are taken only in the idle state.
// A search step builds the rows and reads the derivative banks as it is
// accepted, pivots over the nine columns in turn through the cell chain,
// then finishes.
// The finish cycle holds while the previous result waits in o_out.
// Reset clears control, the output valid flag and the Gray point.
module gf2_mq_gray_search_step import gmq_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    gmq_in_if.sink        i_in,
    gmq_out_if.source     o_out
);
`include "gf2_mq_gray_search_step_defines.svh"

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_ELIM = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state                 r_state, n_state;
    logic [COL_SEL_W-1:0]   r_col, n_col;
    logic [SEARCH_BITS-1:0] r_gray, n_gray;
    logic [SEARCH_BITS-1:0] r_key;
    logic [SEARCH_BITS-1:0] r_guess;
    logic                   r_out_valid;
    logic                   r_solved;
    logic [SEARCH_BITS-1:0] r_key_out;
    logic [SEARCH_BITS-1:0] r_guess_out;
    logic [SOLVED_VARS-1:0] r_solution;

    logic                   w_acc;
    logic                   w_step;
    logic                   w_out_free;
    logic [SEARCH_BITS-1:0] w_gray_key;
    logic [SEARCH_BITS-1:0] w_gray_prev;
    logic [SEARCH_BITS:0]   w_z;
    logic [ADDR_W-1:0]      w_pos;
    t_cell_ctrl             w_ctrl;
    t_cell_stat             w_stat [EQUATIONS];
    logic [EQUATIONS-1:0]   w_deriv_we;
    logic [EQUATIONS-1:0]   w_eq_we;
    logic [EQUATIONS-1:0]   w_pivots;
    logic [EQUATIONS:0]     w_found;
    logic [SOLVED_VARS-1:0] w_seen [EQUATIONS+1];
    logic [ROW_W-1:0]       w_pivot_row;
    logic [SOLVED_VARS-1:0] w_sol;
    logic                   w_bad;

    assign i_in.ready = (r_state == S_IDLE);
    assign w_acc      = i_in.valid & i_in.ready;
    assign w_step     = w_acc & (t_cmd'(i_in.command) == CMD_STEP);
    assign w_out_free = ~r_out_valid | o_out.ready;

    assign w_gray_key  = i_in.key ^ (i_in.key >> 1);
    assign w_gray_prev = (i_in.key - SEARCH_BITS'(1)) ^ ((i_in.key - SEARCH_BITS'(1)) >> 1);

    // Derivative column: lowest set bit of Gray(key) XOR point; bit 46 always set.
    assign w_z = {1'b1, w_gray_key ^ r_gray};
    always_comb begin
        w_pos = ADDR_W'(SEARCH_BITS);
        for (int b = SEARCH_BITS; b >= 0; b--) begin
            if (w_z[b]) begin
                w_pos = ADDR_W'(b);
            end
        end
    end

    // Broadcast the pivot row and gather consistency and solution bits.
    always_comb begin
        w_pivot_row = '0;
        w_sol       = '0;
        w_bad       = 1'b0;
        for (int g = 0; g < EQUATIONS; g++) begin
            w_pivots[g] = w_stat[g].pivot;
            if (w_stat[g].pivot) begin
                w_pivot_row = w_pivot_row | w_stat[g].row;
            end
            w_sol = w_sol | w_stat[g].sol;
            w_bad = w_bad | (w_stat[g].free & w_stat[g].row[SOLVED_VARS]);
        end
    end

    always_comb begin
        w_ctrl           = '0;
        w_ctrl.load      = w_step;
        w_ctrl.rd_en     = w_step;
        w_ctrl.elim      = (r_state == S_ELIM);
        w_ctrl.upd       = (r_state == S_ELIM) && (r_col == '0);
        w_ctrl.col_sel   = r_col;
        w_ctrl.pivot_row = w_pivot_row;
        w_ctrl.wr_addr   = i_in.column;
        w_ctrl.rd_addr   = w_pos;
        w_ctrl.wr_data   = i_in.data;
        w_ctrl.mask      = {GP_TOP, r_guess};
        for (int g = 0; g < EQUATIONS; g++) begin
            w_eq_we[g]    = w_acc && (t_cmd'(i_in.command) == CMD_EQW)
                            && (i_in.row == 5'(g));
            w_deriv_we[g] = w_acc && (t_cmd'(i_in.command) == CMD_DERIV)
                            && (i_in.row == 5'(g)) && (i_in.column < 6'(VARIABLES));
        end
    end

    // Chains run from the top row down: the top row has nothing above it.
    assign w_found[EQUATIONS] = 1'b0;
    assign w_seen[EQUATIONS]  = '0;

    for (genvar g = 0; g < EQUATIONS; g++) begin : g_cell
        gmq_cell u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (w_ctrl),
            .i_deriv_we (w_deriv_we[g]),
            .i_eq_we    (w_eq_we[g]),
            .i_found    (w_found[g+1]),
            .o_found    (w_found[g]),
            .i_seen     (w_seen[g+1]),
            .o_seen     (w_seen[g]),
            .o_stat     (w_stat[g])
        );
    end

    always_comb begin
        n_state = r_state;
        n_col   = r_col;
        n_gray  = r_gray;
        case (r_state)
            S_IDLE: begin
                if (w_acc && (t_cmd'(i_in.command) == CMD_START)) begin
                    n_gray = (i_in.key == '0) ? '0 : w_gray_prev;
                end
                if (w_step) begin
                    n_gray  = w_gray_key;
                    n_col   = '0;
                    n_state = S_ELIM;
                end
            end
            S_ELIM: begin
                // Advance one column per cycle; rewind after the last one.
                if (r_col == COL_SEL_W'(SOLVED_VARS - 1)) begin
                    n_col   = '0;
                    n_state = S_DONE;
                end else begin
                    n_col = r_col + COL_SEL_W'(1);
                end
            end
            S_DONE: begin
                // Hold until the output register is free.
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_col       <= '0;
            r_gray      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
            r_gray  <= n_gray;
            if ((r_state == S_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_key   <= i_in.key;
            r_guess <= r_gray;
        end
        if ((r_state == S_DONE) && w_out_free) begin
            r_solved    <= ~w_bad;
            r_key_out   <= r_key;
            r_guess_out <= r_guess;
            r_solution  <= w_bad ? '0 : w_sol;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.solved     = r_solved;
    assign o_out.key_out    = r_key_out;
    assign o_out.guess_bits = r_guess_out;
    assign o_out.solution   = r_solution;

    `GMQ_ASSERT_ALWAYS(a_one_pivot, $onehot0(w_pivots), "more than one pivot row")
    `GMQ_ASSERT_ALWAYS(a_col_range, r_col < COL_SEL_W'(SOLVED_VARS), "pivot column out of range")
    `GMQ_ASSERT_IMPL(a_step_start, w_step, ##1 (r_state == S_ELIM) && (r_col == '0),
        "step did not enter elimination")
    `GMQ_ASSERT_IMPL(a_result_src, $rose(r_out_valid), $past(r_state == S_DONE),
        "result raised outside finish")
endmodule
